// ===== rtl/delimited_number_parser_assert.svh =====
// assertion macros for the delimited number parser
// no dependencies; included by the top level only
`ifndef DELIMITED_NUMBER_PARSER_ASSERT_SVH
`define DELIMITED_NUMBER_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DNP_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DNP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/dnp_pkg.sv =====
// types, codes and character constants for the delimited number parser
// no dependencies; used by delimited_number_parser
`timescale 1ns / 1ps
`default_nettype none

package dnp_pkg;

    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DIGIT_CNT_W = 4;
    localparam int DIGIT_W     = 5;

    localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_MAX = 4'hF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_DIGIT = 2'd1,
        ST_BAD_CHAR = 2'd2,
        ST_TOO_MANY = 2'd3
    } parse_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX_MODE  = 2'd0,
        REG_MAX_DIGITS  = 2'd1,
        REG_SEPARATOR_A = 2'd2,
        REG_SEPARATOR_B = 2'd3
    } cfg_reg_t;

    localparam logic                   RADIX_MODE_RST  = 1'b1;
    localparam logic [DIGIT_CNT_W-1:0] MAX_DIGITS_RST  = 4'd8;
    localparam logic [CHAR_W-1:0]      SEPARATOR_A_RST = 8'd59;
    localparam logic [CHAR_W-1:0]      SEPARATOR_B_RST = 8'd0;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 5'd16;

    // digit value of a character, bit 4 set when it is not a digit of the radix
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c,
                                                    input logic hex);
        logic [CHAR_W-1:0] diff;
        logic [DIGIT_W-1:0] d;
        d = NOT_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            diff = c - CH_0;
            d    = diff[DIGIT_W-1:0];
        end else if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
            diff = c - CH_UP_A + 8'd10;
            d    = diff[DIGIT_W-1:0];
        end else if (hex && c >= CH_LO_A && c <= CH_LO_F) begin
            diff = c - CH_LO_A + 8'd10;
            d    = diff[DIGIT_W-1:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/delimited_number_parser.sv =====
// Delimited number parser: one character word in, zero or one result word out.
// Channels: s_* carries one 8-bit character per word; m_* carries a result
// word (value, status, step flag) whenever a field ends at a separator, a bad
// character or the hex digit limit. cfg_* writes the four control registers
// (radix mode, hex digit limit, two separator codes) one per cycle.
// A character taken into the input register is decoded against the accumulator;
// its result word loads into the output register, raising m_tvalid, once the
// output can advance. Throughput: one character per cycle while the output is
// not stalled, set by the single decode and multiply-by-ten or shift-by-four
// add between the input and output register.
// Reset: registers return to hex mode, limit 8, separators 59 and 0;
// the accumulator and digit count clear and both registers are empty.
// Stall: a result word holds in the output register until taken; the input
// register holds one more character, then s_tready falls until room returns.
// Depends on dnp_pkg and delimited_number_parser_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "delimited_number_parser_assert.svh"

module delimited_number_parser #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // character stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dnp_pkg::CHAR_W-1:0]        s_tdata,  // [7:0] char_code
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // number_value, parse_status, step_past_terminator, zero fill
    output logic [((VALUE_BITS+3+7)/8)*8-1:0]      m_tdata,
    // control register writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [dnp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dnp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int TDATA_W = ((VALUE_BITS + 3 + 7) / 8) * 8;
    localparam int ST_LSB  = VALUE_BITS;
    localparam int STEP_B  = VALUE_BITS + 2;

    // control registers
    logic                                  radix_mode_reg, radix_mode_next;
    logic [dnp_pkg::DIGIT_CNT_W-1:0]       max_digits_reg, max_digits_next;
    logic [dnp_pkg::CHAR_W-1:0]            separator_a_reg, separator_a_next;
    logic [dnp_pkg::CHAR_W-1:0]            separator_b_reg, separator_b_next;

    // input stage
    logic                                  in_valid_reg, in_valid_next;
    logic [dnp_pkg::CHAR_W-1:0]            char_reg, char_next;

    // field state
    logic [VALUE_BITS-1:0]                 acc_reg, acc_next;
    logic [dnp_pkg::DIGIT_CNT_W-1:0]       cnt_reg, cnt_next;

    // output stage
    logic                                  out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]                    out_data_reg, out_data_next;

    logic                                  advance;
    logic                                  s_take;
    logic                                  is_sep;
    logic                                  at_limit;
    logic [dnp_pkg::DIGIT_W-1:0]           dig;
    logic                                  emit;
    logic [VALUE_BITS-1:0]                 res_value;
    dnp_pkg::parse_status_t                res_status;
    logic                                  res_step;
    logic [VALUE_BITS-1:0]                 acc_digit;
    logic                                  out_load;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // control register writes
    always_comb begin
        radix_mode_next  = radix_mode_reg;
        max_digits_next  = max_digits_reg;
        separator_a_next = separator_a_reg;
        separator_b_next = separator_b_reg;
        if (cfg_wr_en) begin
            case (dnp_pkg::cfg_reg_t'(cfg_index))
                dnp_pkg::REG_RADIX_MODE:  radix_mode_next  = cfg_wdata[0];
                dnp_pkg::REG_MAX_DIGITS:  max_digits_next  =
                    cfg_wdata[dnp_pkg::DIGIT_CNT_W-1:0];
                dnp_pkg::REG_SEPARATOR_A: separator_a_next = cfg_wdata;
                dnp_pkg::REG_SEPARATOR_B: separator_b_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // character decode against the field state
    always_comb begin
        is_sep    = (char_reg == separator_a_reg) || (char_reg == separator_b_reg);
        at_limit  = radix_mode_reg && (cnt_reg >= max_digits_reg);
        dig       = dnp_pkg::digit_of(char_reg, radix_mode_reg);
        acc_digit = radix_mode_reg
                  ? ((acc_reg << 4) + VALUE_BITS'(dig[3:0]))
                  : ((acc_reg << 3) + (acc_reg << 1) + VALUE_BITS'(dig[3:0]));
        emit       = 1'b1;
        res_value  = acc_reg;
        res_status = dnp_pkg::ST_OK;
        res_step   = 1'b0;
        if (at_limit) begin
            res_status = is_sep ? dnp_pkg::ST_OK : dnp_pkg::ST_TOO_MANY;
            res_step   = is_sep && (char_reg != dnp_pkg::CH_NUL);
        end else if (is_sep) begin
            if (cnt_reg == '0) begin
                res_status = dnp_pkg::ST_NO_DIGIT;
                res_value  = '0;
            end else begin
                res_step   = (char_reg != dnp_pkg::CH_NUL);
            end
        end else if (dig[dnp_pkg::DIGIT_W-1]) begin
            res_status = dnp_pkg::ST_BAD_CHAR;
        end else begin
            emit = 1'b0;
        end
    end

    assign out_load = in_valid_reg && advance && emit;

    always_comb begin
        in_valid_next = in_valid_reg;
        char_next     = char_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            char_next     = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (in_valid_reg && advance) begin
            if (emit) begin
                acc_next = '0;
                cnt_next = '0;
            end else begin
                acc_next = acc_digit;
                if (cnt_reg != dnp_pkg::DIGIT_CNT_MAX) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end

        out_data_next = out_data_reg;
        if (out_load) begin
            out_data_next                      = '0;
            out_data_next[VALUE_BITS-1:0]      = res_value;
            out_data_next[ST_LSB+1:ST_LSB]     = res_status;
            out_data_next[STEP_B]              = res_step;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_mode_reg  <= dnp_pkg::RADIX_MODE_RST;
            max_digits_reg  <= dnp_pkg::MAX_DIGITS_RST;
            separator_a_reg <= dnp_pkg::SEPARATOR_A_RST;
            separator_b_reg <= dnp_pkg::SEPARATOR_B_RST;
            in_valid_reg    <= 1'b0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            radix_mode_reg  <= radix_mode_next;
            max_digits_reg  <= max_digits_next;
            separator_a_reg <= separator_a_next;
            separator_b_reg <= separator_b_next;
            in_valid_reg    <= in_valid_next;
            acc_reg         <= acc_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        out_data_reg <= out_data_next;
    end

    // checks
    `DNP_ASSERT_NOW(a_no_digit_zero, aclk, aresetn,
        m_tvalid && (m_tdata[ST_LSB+1:ST_LSB] == dnp_pkg::ST_NO_DIGIT),
        m_tdata[VALUE_BITS-1:0] == '0, "no-digit result carries a non-zero value")
    `DNP_ASSERT_NOW(a_step_only_ok, aclk, aresetn,
        m_tvalid && m_tdata[STEP_B],
        m_tdata[ST_LSB+1:ST_LSB] == dnp_pkg::ST_OK, "step flag set on an error result")
    `DNP_ASSERT_NEXT(a_field_cleared, aclk, aresetn, out_load,
        (acc_reg == '0) && (cnt_reg == '0), "field state not cleared after a result")
    `DNP_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(char_reg), "pending character lost during stall")

endmodule

`default_nettype wire
